// ===== rtl/iod_pkg.sv =====
// Shared types, constants and the step program for the inertial offset decay block.
`timescale 1ns / 1ps
package iod_pkg;

  localparam int TW       = 24;             // time width, Q8.16
  localparam int DW       = 32;             // offset / velocity width
  localparam int DIV_W    = 54;             // dividend and quotient width
  localparam int DVS_W    = 32;             // divisor width
  localparam int DCNT_W   = $clog2(DIV_W);
  localparam int QF       = 30;             // fraction bits of normalized time
  localparam int QW       = QF + 1;         // width of a value in [0, 1] in Q30
  localparam int MA_W     = 34;             // multiplier operand a
  localparam int MB_W     = 32;             // multiplier operand b
  localparam int PROD_W   = MA_W + MB_W;
  localparam int VM_W     = DW + TW;        // |v0| * T
  localparam int G_W      = 60;             // floored acceleration term
  localparam int MAG_W    = QF + MB_W;      // term magnitude
  localparam int ACC_W    = 64;
  localparam logic [TW-1:0] T_MAX = '1;

  typedef enum logic [3:0] {
    OP_NONE, OP_TSEL, OP_SU, OP_VT, OP_SS, OP_UU, OP_U3, OP_P0,
    OP_SU3, OP_P1, OP_P2, OP_GC, OP_TH, OP_TL, OP_TA, OP_FIN
  } op_t;

  typedef enum logic [1:0] {TERM_X, TERM_V, TERM_G} term_t;

  typedef enum logic {DIV_Q, DIV_S} dsel_t;

  typedef enum logic [1:0] {REG_OFFSET, REG_VELOCITY, REG_DURATION, REG_CLAMP} reg_idx_t;

  typedef struct packed {
    op_t   op;
    term_t term;
  } step_t;

  localparam int PROG_LEN = 18;
  localparam int PC_W     = $clog2(PROG_LEN);

  localparam step_t PROG [PROG_LEN] = '{
    '{OP_VT,  TERM_X}, '{OP_SS,  TERM_X}, '{OP_UU,  TERM_X}, '{OP_U3,  TERM_X},
    '{OP_P0,  TERM_X}, '{OP_SU3, TERM_X}, '{OP_P1,  TERM_X}, '{OP_P2,  TERM_X},
    '{OP_GC,  TERM_X},
    '{OP_TH,  TERM_X}, '{OP_TL,  TERM_X}, '{OP_TA,  TERM_X},
    '{OP_TH,  TERM_V}, '{OP_TL,  TERM_V}, '{OP_TA,  TERM_V},
    '{OP_TH,  TERM_G}, '{OP_TL,  TERM_G}, '{OP_TA,  TERM_G}
  };

  typedef struct packed {
    logic  load;
    logic  div_start;
    dsel_t div_sel;
    logic  issue;
    logic  wb;
    op_t   op;
    term_t term;
  } cmd_t;

  typedef struct packed {
    logic shorten;
    logic div_done;
  } sts_t;

  typedef struct packed {
    logic [DW-1:0] start_offset;
    logic [DW-1:0] start_velocity;
    logic [TW-1:0] blend_duration;
    logic          clamp_mode;
  } cfg_t;

  function automatic logic is_mul(op_t op);
    logic r;
    case (op)
      OP_VT, OP_SS, OP_UU, OP_U3, OP_P0, OP_SU3, OP_P1, OP_P2, OP_TH, OP_TL: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/iod_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module iod_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [iod_pkg::DIV_W-1:0]  dividend,
  input  logic [iod_pkg::DVS_W-1:0]  divisor,
  output logic                       done,
  output logic [iod_pkg::DIV_W-1:0]  quotient
);
  import iod_pkg::*;

  logic [DIV_W-1:0]  quo_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DVS_W:0]    rem_sh;
  logic              qbit;
  logic [DVS_W:0]    rem_sub;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_W-1]};
    qbit    = rem_sh >= {1'b0, dvs_r};
    rem_sub = qbit ? rem_sh - {1'b0, dvs_r} : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], qbit};
      rem_r <= rem_sub[DVS_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/iod_dp.sv =====
// Datapath: elapsed time, duration, shared multiplier, divider and result register.
`timescale 1ns / 1ps
module iod_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  iod_pkg::cfg_t            cfg,
  input  iod_pkg::cmd_t            cmd,
  output iod_pkg::sts_t            sts,
  input  logic [iod_pkg::TW-1:0]   time_step,
  input  logic                     restart,
  output logic [iod_pkg::DW-1:0]   offset_value,
  output logic                     done_res
);
  import iod_pkg::*;

  logic [TW-1:0]     elapsed_r;
  logic              done_r;
  logic [TW-1:0]     t_r;
  logic [QW-1:0]     s_r, u_r, s2_r, u2_r, u3_r, su3_r;
  logic [MA_W-1:0]   f0_r;
  logic [MB_W-1:0]   p0_r, p1_r, p2_r;
  logic [VM_W-1:0]   vmag_r;
  logic [G_W-1:0]    g_r;
  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  tacc_r;
  logic [ACC_W-1:0]  sum_r;
  logic [DW-1:0]     res_r;
  logic              res_done_r;

  logic [TW:0]        e_sum;
  logic [TW-1:0]      e_new;
  logic [DW-1:0]      ax, av;
  logic [DIV_W-1:0]   dividend;
  logic [DVS_W-1:0]   divisor;
  logic [DIV_W-1:0]   quotient;
  logic               div_done;
  logic [TW-1:0]      q_sat, t_new, t_clip;
  logic [MA_W-1:0]    mul_a;
  logic [MB_W-1:0]    mul_b;
  logic [MAG_W-1:0]   mag;
  logic [MB_W-1:0]    p_sel;
  logic               neg_sel;
  logic [ACC_W-1:0]   vs, x64, g_full;
  logic [ACC_W-1:0]   adj, r64;
  logic [DW-1:0]      r_sat, r_zero, r_lo, r_fin;
  logic [MA_W+1:0]    f0_full;

  always_comb begin
    e_sum = (restart ? (TW+1)'(0) : {1'b0, elapsed_r}) + {1'b0, time_step};
    e_new = (e_sum > {1'b0, cfg.blend_duration}) ? cfg.blend_duration : e_sum[TW-1:0];
    ax    = cfg.start_offset[DW-1] ? DW'(-cfg.start_offset) : cfg.start_offset;
    av    = cfg.start_velocity[DW-1] ? DW'(-cfg.start_velocity) : cfg.start_velocity;
    sts.shorten = (cfg.start_offset != '0) && (cfg.start_velocity != '0) &&
                  (cfg.start_offset[DW-1] != cfg.start_velocity[DW-1]);
    sts.div_done = div_done;
    q_sat  = (quotient > DIV_W'(T_MAX)) ? T_MAX : quotient[TW-1:0];
    t_new  = (sts.shorten && q_sat < cfg.blend_duration) ? q_sat : cfg.blend_duration;
    t_clip = (elapsed_r > t_r) ? t_r : elapsed_r;
    if (cmd.div_sel == DIV_Q) begin
      dividend = DIV_W'({ax, 6'b0}) + DIV_W'({ax, 4'b0});
      divisor  = av;
    end else begin
      dividend = DIV_W'({t_clip, QF'(0)});
      divisor  = DVS_W'(t_r);
    end
  end

  iod_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // term operand select
  always_comb begin
    case (cmd.term)
      TERM_X: begin
        mag = MAG_W'({ax, 4'b0}); p_sel = p0_r; neg_sel = cfg.start_offset[DW-1];
      end
      TERM_V: begin
        mag = MAG_W'(vmag_r); p_sel = p1_r; neg_sel = cfg.start_velocity[DW-1];
      end
      TERM_G: begin
        mag = MAG_W'(g_r); p_sel = p2_r; neg_sel = 1'b0;
      end
      default: begin
        mag = '0; p_sel = '0; neg_sel = 1'b0;
      end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_VT:  begin mul_a = MA_W'(av);    mul_b = MB_W'(t_r);   end
      OP_SS:  begin mul_a = MA_W'(s_r);   mul_b = MB_W'(s_r);   end
      OP_UU:  begin mul_a = MA_W'(u_r);   mul_b = MB_W'(u_r);   end
      OP_U3:  begin mul_a = MA_W'(u2_r);  mul_b = MB_W'(u_r);   end
      OP_P0:  begin mul_a = f0_r;         mul_b = MB_W'(u3_r);  end
      OP_SU3: begin mul_a = MA_W'(s_r);   mul_b = MB_W'(u3_r);  end
      OP_P1:  begin
        mul_a = (MA_W'(1) << QF) + MA_W'(s_r) + MA_W'({s_r, 1'b0});
        mul_b = MB_W'(su3_r);
      end
      OP_P2:  begin mul_a = MA_W'(s2_r);  mul_b = MB_W'(u3_r);  end
      OP_TH:  begin mul_a = MA_W'(p_sel); mul_b = mag[MAG_W-1:QF]; end
      OP_TL:  begin mul_a = MA_W'(p_sel); mul_b = MB_W'(mag[QF-1:0]); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    f0_full = ((MA_W+2)'(10) << QF) + (MA_W+2)'({u2_r, 2'b0}) + (MA_W+2)'({u2_r, 1'b0})
              - (MA_W+2)'({u_r, 4'b0}) + (MA_W+2)'(u_r);
    vs      = cfg.start_velocity[DW-1] ? ACC_W'(-ACC_W'(vmag_r)) : ACC_W'(vmag_r);
    x64     = ACC_W'($signed(cfg.start_offset));
    g_full  = ACC_W'(0) - (vs << 3) - (x64 << 8) - (x64 << 6);
    adj     = sum_r + (sum_r[ACC_W-1] ? ACC_W'(15) : ACC_W'(0));
    r64     = ACC_W'($signed(adj) >>> 4);
    if ($signed(r64) > $signed(ACC_W'(32'h7fffffff))) begin
      r_sat = 32'h7fffffff;
    end else if ($signed(r64) < $signed({{(ACC_W-DW){1'b1}}, 32'h80000000})) begin
      r_sat = 32'h80000000;
    end else begin
      r_sat = r64[DW-1:0];
    end
    r_zero = (t_r == '0) ? '0 : r_sat;
    r_lo   = (cfg.clamp_mode && r_zero[DW-1]) ? '0 : r_zero;
    r_fin  = (cfg.clamp_mode && $signed(r_lo) > $signed(cfg.start_offset)) ?
             cfg.start_offset : r_lo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
    end else if (cmd.load) begin
      elapsed_r <= e_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      done_r <= (e_new == cfg.blend_duration);
    end
    if (cmd.issue) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd.wb) begin
      case (cmd.op)
        OP_TSEL: t_r <= t_new;
        OP_SU: begin
          s_r   <= quotient[QW-1:0];
          u_r   <= (QW'(1) << QF) - quotient[QW-1:0];
          sum_r <= '0;
        end
        OP_VT:  vmag_r <= prod_r[VM_W-1:0];
        OP_SS:  s2_r   <= prod_r[QF+QW-1:QF];
        OP_UU:  u2_r   <= prod_r[QF+QW-1:QF];
        OP_U3: begin
          u3_r <= prod_r[QF+QW-1:QF];
          f0_r <= f0_full[MA_W-1:0];
        end
        OP_P0:  p0_r  <= prod_r[QF+MB_W-1:QF];
        OP_SU3: su3_r <= prod_r[QF+QW-1:QF];
        OP_P1:  p1_r  <= prod_r[QF+MB_W-1:QF];
        OP_P2:  p2_r  <= prod_r[QF+MB_W:QF+1];
        OP_GC:  g_r   <= g_full[ACC_W-1] ? '0 : g_full[G_W-1:0];
        OP_TH:  tacc_r <= prod_r[ACC_W-1:0];
        OP_TL:  tacc_r <= tacc_r + ACC_W'(prod_r[PROD_W-1:QF]);
        OP_TA:  sum_r  <= neg_sel ? sum_r - tacc_r : sum_r + tacc_r;
        OP_FIN: begin
          res_r      <= r_fin;
          res_done_r <= done_r;
        end
        default: ;
      endcase
    end
  end

  assign offset_value = res_r;
  assign done_res     = res_done_r;

endmodule

// ===== rtl/iod_ctrl.sv =====
// Controller: sequences divisions and the multiply program, owns the handshakes.
`timescale 1ns / 1ps
module iod_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  iod_pkg::sts_t  sts,
  output iod_pkg::cmd_t  cmd
);
  import iod_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DQ, S_WQ, S_TSEL, S_DS, S_WS, S_SU, S_RUN, S_FIN
  } state_t;

  state_t          state_r;
  logic [PC_W-1:0] pc_r;
  logic            phase_r;
  logic            out_tvalid_r;
  logic            accept;
  logic            out_free;
  step_t           step;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_free   = !out_tvalid_r || out_tready;
  assign step       = PROG[pc_r];

  always_comb begin
    cmd           = '0;
    cmd.op        = OP_NONE;
    cmd.term      = TERM_X;
    cmd.div_sel   = DIV_Q;
    cmd.load      = accept;
    case (state_r)
      S_DQ:   cmd.div_start = 1'b1;
      S_TSEL: begin cmd.op = OP_TSEL; cmd.wb = 1'b1; end
      S_DS:   begin cmd.div_start = 1'b1; cmd.div_sel = DIV_S; end
      S_WS:   cmd.div_sel = DIV_S;
      S_SU:   begin cmd.op = OP_SU; cmd.wb = 1'b1; end
      S_RUN: begin
        cmd.op   = step.op;
        cmd.term = step.term;
        if (is_mul(step.op) && !phase_r) begin
          cmd.issue = 1'b1;
        end else begin
          cmd.wb = 1'b1;
        end
      end
      S_FIN: begin
        cmd.op = OP_FIN;
        cmd.wb = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pc_r         <= '0;
      phase_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (state_r == S_FIN && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= sts.shorten ? S_DQ : S_TSEL;
          end
        end
        S_DQ:   state_r <= S_WQ;
        S_WQ:   if (sts.div_done) state_r <= S_TSEL;
        S_TSEL: state_r <= S_DS;
        S_DS:   state_r <= S_WS;
        S_WS:   if (sts.div_done) state_r <= S_SU;
        S_SU: begin
          state_r <= S_RUN;
          pc_r    <= '0;
          phase_r <= 1'b0;
        end
        S_RUN: begin
          if (is_mul(step.op) && !phase_r) begin
            phase_r <= 1'b1;
          end else begin
            phase_r <= 1'b0;
            if (pc_r == PC_W'(PROG_LEN - 1)) begin
              state_r <= S_FIN;
            end else begin
              pc_r <= pc_r + 1'b1;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready) else $error("input taken while busy");
  a_div_done_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_WQ || state_r == S_WS))
    else $error("divider finished outside a wait state");
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> pc_r <= PC_W'(PROG_LEN - 1)) else $error("program counter overrun");
  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wb && cmd.op == OP_FIN) |=> out_tvalid_r) else $error("result lost");
`endif

endmodule

// ===== rtl/inertial_offset_decay.sv =====
// Top level: APB register file, stream ports, controller and datapath.
// Each input item runs one division and the multiply program; a shortened duration adds
// one extra pass through the serial divider.
// A new item is accepted only in the idle state, after the previous result is registered,
// which can wait on out_tready; the 54-step divider and the multiply program set the pace.
// Reset: rst_n synchronous active low; clears registers and elapsed time.
`timescale 1ns / 1ps
module inertial_offset_decay (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] time_step
  input  logic        in_tuser,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] offset_value
  output logic        out_tuser,  // [0] done_res
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import iod_pkg::*;

  cfg_t     cfg_r;
  cmd_t     cmd;
  sts_t     sts;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (idx)
        REG_OFFSET:   cfg_r.start_offset   <= pwdata;
        REG_VELOCITY: cfg_r.start_velocity <= pwdata;
        REG_DURATION: cfg_r.blend_duration <= pwdata[TW-1:0];
        REG_CLAMP:    cfg_r.clamp_mode     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_OFFSET:   prdata = cfg_r.start_offset;
      REG_VELOCITY: prdata = cfg_r.start_velocity;
      REG_DURATION: prdata = 32'(cfg_r.blend_duration);
      REG_CLAMP:    prdata = 32'(cfg_r.clamp_mode);
      default:      prdata = '0;
    endcase
  end

  iod_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  iod_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .cmd          (cmd),
    .sts          (sts),
    .time_step    (in_tdata),
    .restart      (in_tuser),
    .offset_value (out_tdata),
    .done_res     (out_tuser)
  );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the inertial offset decay block: APB setup, stream traffic, checks.
`timescale 1ns / 1ps
module testbench;
  import iod_pkg::*;

  typedef struct {
    logic [TW-1:0] step;
    logic          restart;
  } tick_t;

  typedef struct {
    logic [DW-1:0] offset;
    logic          done;
  } decay_res_t;

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam int WATCHDOG = 20000;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic out_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  inertial_offset_decay u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic signed [DW-1:0] m_x0 = '0;
  logic signed [DW-1:0] m_v0 = '0;
  logic [TW-1:0] m_dur = '0;
  logic m_clamp = 1'b0;
  logic [TW-1:0] m_elapsed = '0;

  tick_t pending_ticks[$];
  decay_res_t expected_res[$];
  tick_t cur_tick;
  int gap_cnt = 0;
  int stall_cnt = 0;
  bit idle_on = 1'b1;
  int fails = 0;
  int n_ticks = 0;
  int n_res = 0;
  int n_phases = 0;
  int quiet = 0;

  function automatic longint mul_q30(longint a, logic [63:0] p);
    logic [63:0] m;
    logic [63:0] r;
    m = (a < 0) ? 64'(-a) : 64'(a);
    r = (m >> 30) * p + (((m & (ONE_Q30 - 1)) * p) >> 30);
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint decay_offset(logic [TW-1:0] t_in);
    longint x0, v0, xs, vs, gs, sum, r;
    logic [63:0] dur, t, q, ax, av, s, u, s2, u2, u3, p0, p1, p2;
    x0 = longint'(m_x0);
    v0 = longint'(m_v0);
    dur = 64'(m_dur);
    t = 64'(t_in);
    if (v0 != 0 && x0 != 0 && ((x0 < 0) != (v0 < 0))) begin
      ax = (x0 < 0) ? 64'(-x0) : 64'(x0);
      av = (v0 < 0) ? 64'(-v0) : 64'(v0);
      q = (64'd80 * ax) / av;
      if (q > 64'hFFFFFF) q = 64'hFFFFFF;
      if (q < dur) dur = q;
    end
    if (t > dur) t = dur;
    if (dur == 0) return 0;
    s = (t << 30) / dur;
    u = ONE_Q30 - s;
    s2 = (s * s) >> 30;
    u2 = (u * u) >> 30;
    u3 = (u2 * u) >> 30;
    p0 = (u3 * (64'd10 * ONE_Q30 + 64'd6 * u2 - 64'd15 * u)) >> 30;
    p1 = (((s * u3) >> 30) * (ONE_Q30 + 64'd3 * s)) >> 30;
    p2 = (s2 * u3) >> 31;
    xs = x0 * 16;
    vs = v0 * longint'(dur);
    gs = -8 * vs - 20 * xs;
    if (gs < 0) gs = 0;
    sum = mul_q30(xs, p0) + mul_q30(vs, p1) + mul_q30(gs, p2);
    r = sum / 16;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  function automatic decay_res_t advance_tick(tick_t tk);
    logic [TW:0] e;
    longint r;
    decay_res_t res;
    e = tk.restart ? '0 : {1'b0, m_elapsed};
    e = e + tk.step;
    if (e > m_dur) e = m_dur;
    m_elapsed = e[TW-1:0];
    r = decay_offset(m_elapsed);
    if (m_clamp) begin
      if (r < 0) r = 0;
      if (r > longint'(m_x0)) r = longint'(m_x0);
    end
    res.offset = r[31:0];
    res.done = (m_elapsed >= m_dur);
    return res;
  endfunction

  // input driver
  always @(posedge clk) begin
    bit holding, nv;
    holding = in_tvalid && !in_tready;
    nv = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_res = {expected_res, advance_tick(cur_tick)};
        n_ticks++;
        gap_cnt = idle_on ? $urandom_range(0, 12) : 0;
      end
      if (!holding) begin
        if (gap_cnt > 0) gap_cnt--;
        else if (pending_ticks.size() > 0) begin
          cur_tick = pending_ticks.pop_front();
          in_tdata <= cur_tick.step;
          in_tuser <= cur_tick.restart;
          nv = 1'b1;
        end
      end
      in_tvalid <= holding ? 1'b1 : nv;
    end
  end

  // result monitor
  always @(posedge clk) begin
    decay_res_t ex;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        n_res++;
        if (expected_res.size() == 0) begin
          fails++;
          $display("%0t unexpected result offset=%h done=%b", $time, out_tdata, out_tuser);
        end else begin
          ex = expected_res.pop_front();
          if (out_tdata !== ex.offset) begin
            fails++;
            $display("%0t offset mismatch exp=%h act=%h", $time, ex.offset, out_tdata);
          end
          if (out_tuser !== ex.done) begin
            fails++;
            $display("%0t done mismatch exp=%b act=%b", $time, ex.done, out_tuser);
          end
        end
        stall_cnt = idle_on ? $urandom_range(0, 12) : 0;
      end else if (stall_cnt > 0) stall_cnt--;
      out_tready <= (stall_cnt == 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || psel) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic apb_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_OFFSET:   m_x0 = val;
      REG_VELOCITY: m_v0 = val;
      REG_DURATION: m_dur = val[TW-1:0];
      REG_CLAMP:    m_clamp = val[0];
      default: ;
    endcase
  endtask

  task automatic set_blend(logic [31:0] x0, logic [31:0] v0, logic [23:0] dur, logic clamp);
    apb_write(REG_OFFSET, x0);
    apb_write(REG_VELOCITY, v0);
    apb_write(REG_DURATION, {8'd0, dur});
    apb_write(REG_CLAMP, {31'd0, clamp});
    n_phases++;
  endtask

  task automatic push_tick(logic [23:0] step, logic restart);
    tick_t tk;
    tk.step = step;
    tk.restart = restart;
    pending_ticks = {pending_ticks, tk};
  endtask

  task automatic drain();
    while (pending_ticks.size() > 0 || in_tvalid || expected_res.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_ticks(int n);
    logic [23:0] st;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: st = 24'($urandom);
        1: st = '0;
        2, 3: st = 24'($urandom_range(0, 64));
        default: st = 24'($urandom_range(0, (m_dur >> 3) + 1));
      endcase
      push_tick(st, $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    logic [31:0] rx, rv;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers at reset: zero duration
    push_tick(24'd100, 1'b0);
    push_tick(24'hFFFFFF, 1'b1);
    drain();

    set_blend(32'h7FFFFFFF, 32'h80000000, 24'hFFFFFF, 1'b0);
    push_tick(24'd0, 1'b1);
    push_tick(24'd1, 1'b0);
    push_tick(24'd3, 1'b0);
    push_tick(24'hFFFFFF, 1'b0);
    drain();

    set_blend(32'h10000000, 32'hFFF00000, 24'h020000, 1'b0);
    for (int i = 0; i < 10; i++) push_tick(24'h004000, i == 0);
    push_tick(24'hFFFFFF, 1'b0);
    push_tick(24'h000100, 1'b1);
    drain();

    set_blend(32'h80000000, 32'h7FFFFFFF, 24'h010000, 1'b1);
    push_tick(24'h001000, 1'b1);
    push_tick(24'h008000, 1'b0);
    drain();

    set_blend(32'h08000000, 32'h00010000, 24'h018000, 1'b1);
    push_tick(24'h002000, 1'b1);
    push_tick(24'h00C000, 1'b0);
    push_tick(24'h00C000, 1'b0);
    drain();

    set_blend(32'h00000001, 32'hFFFFFFFF, 24'h000010, 1'b0);
    push_tick(24'd1, 1'b1);
    push_tick(24'd0, 1'b0);
    drain();

    for (int ph = 0; ph < 14; ph++) begin
      rx = $urandom;
      rv = $urandom;
      rx = $signed(rx) >>> $urandom_range(0, 8);
      rv = $signed(rv) >>> $urandom_range(0, 20);
      if (ph % 3 == 0) rv = (rx[31] == rv[31]) ? ~rv : rv;
      if (ph == 5) rv = '0;
      idle_on = (ph % 4 != 3);
      set_blend(rx, rv, (ph % 5 == 0) ? 24'(int'($urandom)) : 24'($urandom_range(1, 24'h040000)),
                1'($urandom_range(0, 1)));
      random_ticks(95);
      drain();
    end

    $display("covered %0d configurations, %0d ticks sent, %0d results checked",
             n_phases, n_ticks, n_res);
    $display("mismatches: %0d", fails);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
